/* hw/rtl/isc_pkg.sv */
// Package for the identifier case converter.
// Holds the transaction structs, converter state, result buffer type and byte constants.
// No dependencies.
package isc_pkg;

	// Result bytes that the buffer can hold for one input byte
	localparam int MaxResults = 6;
	localparam int CntW = $clog2(MaxResults + 1);

	// Byte constants
	localparam logic [7:0] ByteLead     = 8'hC3;
	localparam logic [7:0] ByteAeLower  = 8'hA4;
	localparam logic [7:0] ByteOeLower  = 8'hB6;
	localparam logic [7:0] ByteUeLower  = 8'hBC;
	localparam logic [7:0] ByteAeUpper  = 8'h84;
	localparam logic [7:0] ByteOeUpper  = 8'h96;
	localparam logic [7:0] ByteUeUpper  = 8'h9C;
	localparam logic [7:0] ByteSharpS   = 8'h9F;
	localparam logic [7:0] CharUnder    = 8'h5F;
	localparam logic [7:0] CharA        = 8'h61;
	localparam logic [7:0] CharO        = 8'h6F;
	localparam logic [7:0] CharU        = 8'h75;
	localparam logic [7:0] CharS        = 8'h73;
	localparam logic [7:0] CaseOffset   = 8'd32;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_in;
	} in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic       last_out;
	} out_t;

	typedef struct packed {
		logic [7:0] held_byte;
		logic       held_present;
		logic       prev_lower;
		logic       prev_upper;
		logic       prev_separator;
		logic       pending_underscore;
		logic       emitted_any;
	} state_t;

	localparam state_t StateReset = '{
		held_byte:          8'h00,
		held_present:       1'b0,
		prev_lower:         1'b0,
		prev_upper:         1'b0,
		prev_separator:     1'b1,
		pending_underscore: 1'b0,
		emitted_any:        1'b0
	};

	// Results of one input byte, as loaded into the output buffer
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [CntW-1:0]            cnt;
		logic                       last;
		logic                       empty_end;
	} result_t;

endpackage

/* hw/rtl/isc_step.sv */
// Combinational conversion step of the identifier case converter.
// Takes the held state and one input byte, gives the next state and the result bytes.
// Depends on isc_pkg.
module isc_step (
	input  isc_pkg::state_t  state,
	input  isc_pkg::in_t     item,
	output isc_pkg::state_t  next_state,
	output isc_pkg::result_t result
);

	typedef struct packed {
		isc_pkg::state_t                     st;
		logic [isc_pkg::MaxResults-1:0][7:0] bytes;
		logic [isc_pkg::CntW-1:0]            cnt;
	} work_t;

	function automatic logic is_lower(input logic [7:0] b);
		return b inside {[8'h61:8'h7A]};
	endfunction

	function automatic logic is_capital(input logic [7:0] b);
		return b inside {[8'h41:8'h5A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	// Append one byte if there is room
	function automatic work_t put_raw(input work_t w, input logic [7:0] b);
		work_t r;
		r = w;
		if (r.cnt < isc_pkg::CntW'(isc_pkg::MaxResults)) begin
			r.bytes[r.cnt[isc_pkg::CntW-1:0]] = b;
			r.cnt = r.cnt + isc_pkg::CntW'(1);
		end
		return r;
	endfunction

	// Flush a pending separator underscore, then append the byte
	function automatic work_t emit(input work_t w, input logic [7:0] b);
		work_t r;
		r = w;
		if (r.st.pending_underscore) begin
			r.st.pending_underscore = 1'b0;
			r = put_raw(r, isc_pkg::CharUnder);
		end
		r = put_raw(r, b);
		r.st.emitted_any = 1'b1;
		return r;
	endfunction

	function automatic logic foldable(input logic [7:0] second);
		return second inside {isc_pkg::ByteAeLower, isc_pkg::ByteOeLower,
			isc_pkg::ByteUeLower, isc_pkg::ByteAeUpper, isc_pkg::ByteOeUpper,
			isc_pkg::ByteUeUpper, isc_pkg::ByteSharpS};
	endfunction

	// Fold a known C3 pair into its ASCII letters
	function automatic work_t fold(input work_t w, input logic [7:0] second);
		work_t      r;
		logic [7:0] letter;
		logic       cap;
		r = w;
		letter = isc_pkg::CharA;
		cap = 1'b0;
		case (second)
			isc_pkg::ByteAeLower: begin letter = isc_pkg::CharA; cap = 1'b0; end
			isc_pkg::ByteOeLower: begin letter = isc_pkg::CharO; cap = 1'b0; end
			isc_pkg::ByteUeLower: begin letter = isc_pkg::CharU; cap = 1'b0; end
			isc_pkg::ByteAeUpper: begin letter = isc_pkg::CharA; cap = 1'b1; end
			isc_pkg::ByteOeUpper: begin letter = isc_pkg::CharO; cap = 1'b1; end
			isc_pkg::ByteUeUpper: begin letter = isc_pkg::CharU; cap = 1'b1; end
			default: begin letter = isc_pkg::CharS; cap = 1'b0; end
		endcase
		if (second == isc_pkg::ByteSharpS) begin
			r = emit(r, isc_pkg::CharS);
			r = emit(r, isc_pkg::CharS);
			r.st.prev_lower = 1'b1;
			r.st.prev_upper = 1'b0;
		end else begin
			if (cap && r.st.prev_lower && !r.st.prev_separator)
				r = emit(r, isc_pkg::CharUnder);
			r = emit(r, letter);
			r.st.prev_lower = !cap;
			r.st.prev_upper = cap;
		end
		r.st.prev_separator = 1'b0;
		return r;
	endfunction

	// Convert one byte on its own, given its follower if known
	function automatic work_t single(input work_t w, input logic [7:0] b,
			input logic has_next, input logic [7:0] nxt);
		work_t r;
		r = w;
		if (is_capital(b)) begin
			if (r.st.prev_lower && !r.st.prev_separator)
				r = emit(r, isc_pkg::CharUnder);
			else if (r.st.prev_upper && !r.st.prev_separator && has_next && is_lower(nxt))
				r = emit(r, isc_pkg::CharUnder);
			r = emit(r, b + isc_pkg::CaseOffset);
			r.st.prev_lower = 1'b0;
			r.st.prev_upper = 1'b1;
			r.st.prev_separator = 1'b0;
		end else if (is_lower(b)) begin
			r = emit(r, b);
			r.st.prev_lower = 1'b1;
			r.st.prev_upper = 1'b0;
			r.st.prev_separator = 1'b0;
		end else if (is_digit(b)) begin
			r = emit(r, b);
			r.st.prev_lower = 1'b0;
			r.st.prev_upper = 1'b0;
			r.st.prev_separator = 1'b0;
		end else begin
			if (!r.st.prev_separator && r.st.emitted_any) begin
				r.st.pending_underscore = 1'b1;
				r.st.prev_separator = 1'b1;
			end
			r.st.prev_lower = 1'b0;
			r.st.prev_upper = 1'b0;
		end
		return r;
	endfunction

	// Process the held byte against the new one, then the new byte on the final transaction
	always_comb begin
		work_t w;
		logic  consumed;
		w.st = state;
		w.bytes = '0;
		w.cnt = '0;
		consumed = 1'b0;
		if (state.held_present) begin
			w.st.held_present = 1'b0;
			if (state.held_byte == isc_pkg::ByteLead && foldable(item.char_in)) begin
				w = fold(w, item.char_in);
				consumed = 1'b1;
			end else begin
				w = single(w, state.held_byte, 1'b1, item.char_in);
			end
		end
		if (!item.last_in) begin
			if (!consumed) begin
				w.st.held_byte = item.char_in;
				w.st.held_present = 1'b1;
			end
		end else if (!consumed) begin
			w = single(w, item.char_in, 1'b0, 8'h00);
		end

		result.bytes = w.bytes;
		result.last = item.last_in;
		result.empty_end = item.last_in && (w.cnt == '0);
		result.cnt = result.empty_end ? isc_pkg::CntW'(1) : w.cnt;
		next_state = item.last_in ? isc_pkg::StateReset : w.st;
	end

endmodule

/* hw/rtl/identifier_snake_case_converter.sv */
// Top level of the identifier case converter.
// Input register, conversion step and a result buffer that drains one byte per cycle while out_ready is high.
// Depends on isc_pkg and isc_step.
//
//   channel | signals                          | payload
//   --------+----------------------------------+----------------------------------
//   input   | in_valid, in_ready, in_data      | char_in, last_in
//   output  | out_valid, out_ready, out_data   | char_out, char_valid, last_out
//
// A transaction enters the input register, then is converted combinationally into a
// result buffer of up to six bytes that drains one byte per cycle unless stalled. A
// byte with n results occupies the output for n transfers; bytes with no result pass
// at one per cycle. The next transaction loads as the last result of the current one is taken.
// Reset clears the control state and puts the converter at the start of an identifier.
// A stalled output holds the buffer; in_ready drops once the input register waits too.
module identifier_snake_case_converter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  isc_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output isc_pkg::out_t   out_data
);

	logic                                s1_valid_q;
	isc_pkg::in_t                        item_s1;
	isc_pkg::state_t                     state_q;
	isc_pkg::state_t                     next_state;
	isc_pkg::result_t                    result;
	logic [isc_pkg::MaxResults-1:0][7:0] bytes_q;
	logic [isc_pkg::CntW-1:0]            cnt_q;
	logic [isc_pkg::CntW-1:0]            idx_q;
	logic                                last_q;
	logic                                empty_q;
	logic                                in_accept;
	logic                                pop;
	logic                                last_pop;
	logic                                load;

	isc_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.next_state (next_state),
		.result     (result)
	);

	// Handshake and buffer control
	assign in_ready  = !s1_valid_q || (cnt_q == '0);
	assign in_accept = in_valid && in_ready;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign last_pop  = pop && (idx_q == cnt_q - isc_pkg::CntW'(1));
	assign load      = s1_valid_q && ((cnt_q == '0) || last_pop);

	// Drive the current buffered byte
	assign out_data.char_out   = empty_q ? 8'h00 : bytes_q[idx_q];
	assign out_data.char_valid = !empty_q;
	assign out_data.last_out   = last_q && (idx_q == cnt_q - isc_pkg::CntW'(1));

	// Hold the input transaction until the step takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	// Advance converter state and the buffer read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isc_pkg::StateReset;
			cnt_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (load) begin
			state_q <= next_state;
			cnt_q   <= result.cnt;
			idx_q   <= '0;
			last_q  <= result.last;
			empty_q <= result.empty_end;
		end else if (last_pop) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_q + isc_pkg::CntW'(1);
		end
	end

	// Capture result bytes
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= result.bytes;
		end
	end

endmodule
